// ----- sv/wsd_pkg.sv -----
// Shared types, constants and helpers for the WebSocket frame deframer.
package wsd_pkg;

  // Width of the payload length field on the result channel.
  localparam int PLEN_W = 63;
  // Largest length passed through; longer lengths saturate to LEN_MAX.
  localparam int LEN_W = 63;
  localparam logic [63:0] LEN_MAX = (64'd1 << LEN_W) - 64'd1;

  // Second-byte length codes that announce an extended length.
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Last byte index of an extended length and of the masking key.
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST = 3'd3;

  // Defined opcodes.
  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_BIN = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING = 4'h9;
  localparam logic [3:0] OP_PONG = 4'hA;

  // Result kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT = 5'b00100,
    PH_KEY = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  typedef struct packed {
    logic kind;
    logic [7:0] payload_byte;
    logic final_flag;
    logic [2:0] reserved_bits;
    logic [3:0] frame_opcode;
    logic opcode_unknown;
    logic masked;
    logic [PLEN_W-1:0] payload_length;
    logic length_overflow;
    logic frame_end;
  } result_t;

  function automatic logic opcode_known(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
           (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

// ----- sv/wsd_byte_if.sv -----
// Byte stream channel: valid/ready handshake carrying one raw frame byte.
interface wsd_byte_if;
  logic valid;
  logic ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ----- sv/wsd_res_if.sv -----
// Result channel: valid/ready handshake carrying one header or payload result.
interface wsd_res_if
  import wsd_pkg::*;
;
  logic valid;
  logic ready;
  logic kind;
  logic [7:0] payload_byte;
  logic final_flag;
  logic [2:0] reserved_bits;
  logic [3:0] frame_opcode;
  logic opcode_unknown;
  logic masked;
  logic [PLEN_W-1:0] payload_length;
  logic length_overflow;
  logic frame_end;

  modport source (
    output valid, output kind, output payload_byte, output final_flag,
    output reserved_bits, output frame_opcode, output opcode_unknown,
    output masked, output payload_length, output length_overflow,
    output frame_end, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input final_flag,
    input reserved_bits, input frame_opcode, input opcode_unknown,
    input masked, input payload_length, input length_overflow,
    input frame_end, output ready
  );
endinterface

// ----- sv/websocket_frame_deframer.sv -----
// WebSocket frame deframer: header parser, payload unmasking and output buffering.
// Each result is registered; input stalls while the skid register holds one.
// Throughput otherwise: one input item per cycle; each item makes at most one result.
// A two-entry output buffer (result register plus skid register) lets header bytes
// and one more result keep flowing while the result side stalls.
// Reset (rst, synchronous, active high) returns the parser to the first header byte
// and empties the output buffer.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input logic clk,
  input logic rst,
  wsd_byte_if.sink frames,
  wsd_res_if.source results
);

  // Parser state
  phase_t phase, phase_next;
  logic [7:0] header_bits, header_bits_next;
  logic mask_present, mask_present_next;
  logic [2:0] byte_counter, byte_counter_next;
  logic [63:0] length_acc, length_acc_next;
  logic [31:0] masking_key, masking_key_next;
  logic [PLEN_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [1:0] key_index, key_index_next;
  logic long_len, long_len_next;
  logic sat_flag, sat_flag_next;

  // Output buffer: result register and skid register
  result_t out_reg, skid_reg, res_new;
  logic out_valid, skid_valid;

  logic accept, produce, pop;
  logic len_done, finish, data_end;
  logic [63:0] len_pre;
  logic [7:0] key_byte;

  // The skid register is the only thing that can block the input side.
  assign frames.ready = !skid_valid;
  assign accept = frames.valid && frames.ready;
  assign pop = out_valid && results.ready;

  // Key byte for the current payload position, most significant byte first.
  always_comb begin
    unique case (key_index)
      2'd0: key_byte = masking_key[31:24];
      2'd1: key_byte = masking_key[23:16];
      2'd2: key_byte = masking_key[15:8];
      2'd3: key_byte = masking_key[7:0];
      default: key_byte = masking_key[7:0];
    endcase
  end

  // Only the last payload byte sees a count of one.
  assign data_end = (bytes_remaining[PLEN_W-1:1] == '0);

  always_comb begin
    phase_next = phase;
    header_bits_next = header_bits;
    mask_present_next = mask_present;
    byte_counter_next = byte_counter;
    length_acc_next = length_acc;
    masking_key_next = masking_key;
    bytes_remaining_next = bytes_remaining;
    key_index_next = key_index;
    long_len_next = long_len;
    sat_flag_next = sat_flag;
    len_done = 1'b0;
    finish = 1'b0;
    produce = 1'b0;
    len_pre = '0;
    res_new = '0;

    unique case (phase)
      PH_HDR0: begin
        // Start a new frame: clear the header state left from the previous one.
        header_bits_next = frames.in_byte;
        mask_present_next = 1'b0;
        masking_key_next = '0;
        length_acc_next = '0;
        sat_flag_next = 1'b0;
        long_len_next = 1'b0;
        byte_counter_next = '0;
        phase_next = PH_HDR1;
      end
      PH_HDR1: begin
        mask_present_next = frames.in_byte[7];
        byte_counter_next = '0;
        length_acc_next = '0;
        if (frames.in_byte[6:0] == LEN_CODE_EXT16) begin
          long_len_next = 1'b0;
          phase_next = PH_EXT;
        end else if (frames.in_byte[6:0] == LEN_CODE_EXT64) begin
          long_len_next = 1'b1;
          phase_next = PH_EXT;
        end else begin
          length_acc_next = {57'd0, frames.in_byte[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXT: begin
        // Big-endian length: shift in one byte per item.
        length_acc_next = {length_acc[55:0], frames.in_byte};
        if (byte_counter == (long_len ? EXT64_LAST : EXT16_LAST)) begin
          byte_counter_next = '0;
          len_done = 1'b1;
        end else begin
          byte_counter_next = byte_counter + 3'd1;
        end
      end
      PH_KEY: begin
        masking_key_next = {masking_key[23:0], frames.in_byte};
        if (byte_counter >= KEY_LAST) begin
          byte_counter_next = '0;
          finish = 1'b1;
        end else begin
          byte_counter_next = byte_counter + 3'd1;
        end
      end
      PH_DATA: begin
        key_index_next = key_index + 2'd1;
        if (bytes_remaining != '0) begin
          bytes_remaining_next = bytes_remaining - {{(PLEN_W-1){1'b0}}, 1'b1};
        end
        produce = 1'b1;
        res_new.kind = KIND_DATA;
        res_new.payload_byte = frames.in_byte ^ key_byte;
        res_new.frame_end = data_end;
        if (data_end) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase

    // Length known: fetch the key if there is one, else close the header.
    if (len_done) begin
      if (mask_present_next) begin
        byte_counter_next = '0;
        phase_next = PH_KEY;
      end else begin
        finish = 1'b1;
      end
    end

    // Header complete: saturate the length, load the payload count, report it.
    if (finish) begin
      len_pre = length_acc_next;
      if (len_pre > LEN_MAX) begin
        length_acc_next = LEN_MAX;
        sat_flag_next = 1'b1;
      end
      bytes_remaining_next = length_acc_next[PLEN_W-1:0];
      key_index_next = '0;
      produce = 1'b1;
      res_new.kind = KIND_HEADER;
      res_new.payload_byte = '0;
      res_new.frame_end = (len_pre == '0);
      phase_next = (len_pre == '0) ? PH_HDR0 : PH_DATA;
    end

    // Frame fields common to both result kinds.
    res_new.final_flag = header_bits_next[7];
    res_new.reserved_bits = header_bits_next[6:4];
    res_new.frame_opcode = header_bits_next[3:0];
    res_new.opcode_unknown = !opcode_known(header_bits_next[3:0]);
    res_new.masked = mask_present_next;
    res_new.payload_length = length_acc_next[PLEN_W-1:0];
    res_new.length_overflow = sat_flag_next;
  end

  // Parser state: advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
      header_bits <= '0;
      mask_present <= 1'b0;
      byte_counter <= '0;
      length_acc <= '0;
      masking_key <= '0;
      bytes_remaining <= '0;
      key_index <= '0;
      long_len <= 1'b0;
      sat_flag <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      header_bits <= header_bits_next;
      mask_present <= mask_present_next;
      byte_counter <= byte_counter_next;
      length_acc <= length_acc_next;
      masking_key <= masking_key_next;
      bytes_remaining <= bytes_remaining_next;
      key_index <= key_index_next;
      long_len <= long_len_next;
      sat_flag <= sat_flag_next;
    end
  end

  // Output buffer control: the skid register fills only when the result
  // register is held; it drains into the result register on the next pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept && produce) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_reg <= skid_reg;
      end
    end else if (accept && produce) begin
      if (out_valid && !pop) begin
        skid_reg <= res_new;
      end else begin
        out_reg <= res_new;
      end
    end
  end

  assign results.valid = out_valid;
  assign results.kind = out_reg.kind;
  assign results.payload_byte = out_reg.payload_byte;
  assign results.final_flag = out_reg.final_flag;
  assign results.reserved_bits = out_reg.reserved_bits;
  assign results.frame_opcode = out_reg.frame_opcode;
  assign results.opcode_unknown = out_reg.opcode_unknown;
  assign results.masked = out_reg.masked;
  assign results.payload_length = out_reg.payload_length;
  assign results.length_overflow = out_reg.length_overflow;
  assign results.frame_end = out_reg.frame_end;

  // The skid register never holds an item while the result register is empty.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while result register empty");

  // A payload phase always has at least one byte left to deliver.
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_remaining != '0))
    else $error("payload phase with zero bytes remaining");

  // The last payload byte returns the parser to the first header byte.
  a_end_to_hdr0: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_DATA && data_end) |=> (phase == PH_HDR0))
    else $error("parser did not return to header after last payload byte");

endmodule

// ----- bench/websocket_frame_deframer_tb.sv -----
// Deframer testbench: directed and random WebSocket frame streams checked by a predictor.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb
  import wsd_pkg::*;
;

  // Cycles with no handshake on either side before the run is declared hung.
  // The longest legal quiet stretch is the long receiver hold-off (LONG_HOLD).
  localparam int QUIET_LIMIT = 3000;
  // Cycles the receiver holds ready low once, mid-stream, to back up the block.
  localparam int LONG_HOLD = 300;
  // Minimum input bytes per random chunk; the sender drains fully between chunks.
  localparam int CHUNK_BYTES = 360;
  localparam int NUM_CHUNKS = 3;
  // Mismatch lines printed before further ones are only counted.
  localparam int PRINT_LIMIT = 30;

  // How the payload length is encoded in the header.
  typedef enum int {
    FORM_SHORT,
    FORM_EXT16,
    FORM_EXT64
  } len_form_t;

  logic clk = 1'b0;
  logic rst;

  wsd_byte_if frames_if();
  wsd_res_if results_if();

  websocket_frame_deframer i_dut (
    .clk(clk),
    .rst(rst),
    .frames(frames_if),
    .results(results_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Raw bytes waiting to be offered; the head is the one on the bus.
  logic [7:0] pending_bytes[$];
  // Results the deframer owes us, oldest first.
  result_t expected_results[$];

  int bytes_queued = 0;
  int bytes_taken = 0;
  int mismatches = 0;
  int results_seen = 0;
  int hdr_count = 0;
  int masked_hdrs = 0;
  int unknown_hdrs = 0;
  int sat_hdrs = 0;
  int data_count = 0;
  int frames_closed = 0;

  // Print one line per mismatch (up to PRINT_LIMIT) and count it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at result %0d, %s: got %0h, expected %0h",
               results_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Frame parser predictor. Mirrors the deframer's parse state and queues the
  // header and payload results that each accepted byte produces.
  // ---------------------------------------------------------------------------
  phase_t parse_at;
  logic [7:0] hdr_bits;
  logic key_on;
  logic ext_long;
  logic [2:0] ext_count;
  logic [63:0] len_acc;
  logic len_sat;
  logic [31:0] mask_key;
  logic [63:0] len_left;
  logic [1:0] key_pos;

  // Fill every result field from the current frame's header state.
  function automatic result_t frame_result(input logic kind, input logic [7:0] data,
                                           input logic last);
    result_t r;
    r.kind = kind;
    r.payload_byte = data;
    r.final_flag = hdr_bits[7];
    r.reserved_bits = hdr_bits[6:4];
    r.frame_opcode = hdr_bits[3:0];
    case (hdr_bits[3:0])
      OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG: r.opcode_unknown = 1'b0;
      default: r.opcode_unknown = 1'b1;
    endcase
    r.masked = key_on;
    r.payload_length = len_acc[PLEN_W-1:0];
    r.length_overflow = len_sat;
    r.frame_end = last;
    return r;
  endfunction

  // Append one result to the tail of the expectation queue.
  task automatic expect_result(input result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // Header complete: saturate the length, emit the header result and either
  // start the payload or, for an empty frame, go back to the first header byte.
  task automatic close_header();
    if (ext_long && len_acc[63]) begin
      len_acc = LEN_MAX;
      len_sat = 1'b1;
    end else if (len_acc > LEN_MAX) begin
      len_acc = LEN_MAX;
      len_sat = 1'b1;
    end
    len_left = len_acc;
    key_pos = 2'd0;
    expect_result(frame_result(KIND_HEADER, 8'h00, len_acc == 64'd0));
    parse_at = (len_acc == 64'd0) ? PH_HDR0 : PH_DATA;
  endtask

  // Length known: collect the masking key if there is one, else close the header.
  task automatic length_done();
    if (key_on) begin
      ext_count = 3'd0;
      parse_at = PH_KEY;
    end else begin
      close_header();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] key_byte;
    logic last;
    case (parse_at)
      PH_HDR0: begin
        hdr_bits = b;
        key_on = 1'b0;
        mask_key = '0;
        len_acc = '0;
        len_sat = 1'b0;
        ext_long = 1'b0;
        ext_count = 3'd0;
        parse_at = PH_HDR1;
      end
      PH_HDR1: begin
        key_on = b[7];
        ext_count = 3'd0;
        len_acc = '0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          ext_long = 1'b0;
          parse_at = PH_EXT;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          ext_long = 1'b1;
          parse_at = PH_EXT;
        end else begin
          len_acc = {57'd0, b[6:0]};
          length_done();
        end
      end
      PH_EXT: begin
        // Big-endian, shifted in unsigned.
        len_acc = {len_acc[55:0], b};
        if (ext_count == (ext_long ? EXT64_LAST : EXT16_LAST)) begin
          ext_count = 3'd0;
          length_done();
        end else begin
          ext_count = ext_count + 3'd1;
        end
      end
      PH_KEY: begin
        mask_key = {mask_key[23:0], b};
        if (ext_count >= KEY_LAST) begin
          ext_count = 3'd0;
          close_header();
        end else begin
          ext_count = ext_count + 3'd1;
        end
      end
      PH_DATA: begin
        // Key bytes are applied first-received first; an unmasked key is zero.
        key_byte = mask_key[8*(3-key_pos) +: 8];
        key_pos = key_pos + 2'd1;
        if (len_left != 64'd0) len_left = len_left - 64'd1;
        last = (len_left == 64'd0);
        expect_result(frame_result(KIND_DATA, b ^ key_byte, last));
        if (last) parse_at = PH_HDR0;
      end
      default: parse_at = PH_HDR0;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  // Append one raw byte to the tail of the send queue.
  task automatic queue_byte(input logic [7:0] v);
    pending_bytes.insert(pending_bytes.size(), v);
    bytes_queued++;
  endtask

  // Queue one complete frame: header, extended length, key, then n_payload
  // random bytes (fewer than the length only for the endless final frame).
  task automatic queue_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic masked, input len_form_t form,
                             input logic [63:0] len, input int n_payload);
    queue_byte({fin, rsv, op});
    case (form)
      FORM_SHORT: queue_byte({masked, len[6:0]});
      FORM_EXT16: begin
        queue_byte({masked, LEN_CODE_EXT16});
        for (int i = 1; i >= 0; i--) queue_byte(len[8*i +: 8]);
      end
      default: begin
        queue_byte({masked, LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) queue_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 0; i < 4; i++) queue_byte(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < n_payload; i++) queue_byte(8'($urandom_range(0, 255)));
  endtask

  // Mostly short frames, some 16-bit and 64-bit encodings (often non-minimal),
  // a few empty frames and a few hundred-byte ones. Header bits all random.
  task automatic queue_random_frame();
    int sel;
    len_form_t form;
    logic [63:0] len;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      form = FORM_SHORT;
      if (sel < 6) len = 64'd0;
      else if ($urandom_range(0, 9) == 0) len = 64'd125;
      else len = 64'($urandom_range(1, 24));
    end else if (sel < 85) begin
      form = FORM_EXT16;
      len = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(126, 300))
                                        : 64'($urandom_range(0, 40));
    end else begin
      form = FORM_EXT64;
      len = 64'($urandom_range(0, 40));
    end
    queue_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), form, len, int'(len));
  endtask

  // Hold the sender off until everything queued has been taken and answered.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames:
    // empty unmasked text frame, header result ends the frame
    queue_frame(1'b1, 3'd0, OP_TEXT, 1'b0, FORM_SHORT, 64'd0, 0);
    // masked binary frame of two bytes
    queue_frame(1'b1, 3'd0, OP_BIN, 1'b1, FORM_SHORT, 64'd2, 2);
    // unknown opcode, FIN clear, one byte behind a non-minimal 16-bit length
    queue_frame(1'b0, 3'd0, 4'hF, 1'b0, FORM_EXT16, 64'd1, 1);
    // all reserved bits, pong, one byte behind a non-minimal 64-bit length
    queue_frame(1'b1, 3'd7, OP_PONG, 1'b0, FORM_EXT64, 64'd1, 1);
    wait_drained();

    // Random chunks; the sender pauses for a full drain after each.
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      int chunk_start;
      chunk_start = bytes_queued;
      while (bytes_queued - chunk_start < CHUNK_BYTES) queue_random_frame();
      wait_drained();
    end

    // A 64-bit length with the top bit set saturates and never ends, so it
    // goes last: a masked frame followed by some of its payload.
    queue_frame(1'b1, 3'd0, OP_BIN, 1'b1, FORM_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 40);
    wait_drained();

    // Give the block room to emit anything extra it should not.
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results still expected", 64'(expected_results.size()), 64'd0);

    $display("covered %0d input bytes: %0d headers (%0d masked, %0d unknown opcode, %0d %s)",
             bytes_taken, hdr_count, masked_hdrs, unknown_hdrs, sat_hdrs, "saturated");
    $display("%0d payload bytes, %0d frames closed, %0d results checked, %0d mismatches",
             data_count, frames_closed, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers the head of pending_bytes in bursts of random length with
  // random gaps, holding an item until it is taken.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      frames_if.valid <= 1'b0;
      frames_if.in_byte <= 8'h00;
      parse_at = PH_HDR0;
      hdr_bits = '0;
      key_on = 1'b0;
      ext_long = 1'b0;
      ext_count = '0;
      len_acc = '0;
      len_sat = 1'b0;
      mask_key = '0;
      len_left = '0;
      key_pos = '0;
    end else begin
      if (frames_if.valid && frames_if.ready) begin
        deframe_byte(frames_if.in_byte);
        void'(pending_bytes.pop_front());
        bytes_taken++;
      end
      if (frames_if.valid && !frames_if.ready) begin
        // hold the item on the bus until it is taken
      end else if (gap_left != 0) begin
        gap_left--;
        frames_if.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        frames_if.valid <= 1'b1;
        frames_if.in_byte <= pending_bytes[0];
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          // A quarter of bursts run back to back with no gap after them.
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        frames_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a pattern that cycles through always-ready,
  // coin-flip, mostly-stalled and a fixed toggle. Once, mid-stream, it holds
  // ready low so the output buffer fills and input stalls.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  logic [8:0] stall_cycle = '0;

  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      results_if.ready <= 1'b0;
    end else if (!long_hold_done && bytes_taken >= 500) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      results_if.ready <= 1'b0;
    end else begin
      stall_cycle = stall_cycle + 9'd1;
      case (stall_cycle[8:7])
        2'd0: results_if.ready <= 1'b1;
        2'd1: results_if.ready <= 1'($urandom_range(0, 1));
        2'd2: results_if.ready <= ($urandom_range(0, 3) == 0);
        default: results_if.ready <= stall_cycle[2];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      got.kind = results_if.kind;
      got.payload_byte = results_if.payload_byte;
      got.final_flag = results_if.final_flag;
      got.reserved_bits = results_if.reserved_bits;
      got.frame_opcode = results_if.frame_opcode;
      got.opcode_unknown = results_if.opcode_unknown;
      got.masked = results_if.masked;
      got.payload_length = results_if.payload_length;
      got.length_overflow = results_if.length_overflow;
      got.frame_end = results_if.frame_end;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected, kind", 64'(got.kind), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("kind", 64'(got.kind), 64'(want.kind));
        if (got.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
        if (got.final_flag !== want.final_flag)
          report_mismatch("final_flag", 64'(got.final_flag), 64'(want.final_flag));
        if (got.reserved_bits !== want.reserved_bits)
          report_mismatch("reserved_bits", 64'(got.reserved_bits), 64'(want.reserved_bits));
        if (got.frame_opcode !== want.frame_opcode)
          report_mismatch("frame_opcode", 64'(got.frame_opcode), 64'(want.frame_opcode));
        if (got.opcode_unknown !== want.opcode_unknown)
          report_mismatch("opcode_unknown", 64'(got.opcode_unknown), 64'(want.opcode_unknown));
        if (got.masked !== want.masked)
          report_mismatch("masked", 64'(got.masked), 64'(want.masked));
        if (got.payload_length !== want.payload_length)
          report_mismatch("payload_length", 64'(got.payload_length), 64'(want.payload_length));
        if (got.length_overflow !== want.length_overflow)
          report_mismatch("length_overflow", 64'(got.length_overflow),
                          64'(want.length_overflow));
        if (got.frame_end !== want.frame_end)
          report_mismatch("frame_end", 64'(got.frame_end), 64'(want.frame_end));
        // Tally what the run exercised, from the expected side.
        if (want.kind == KIND_HEADER) begin
          hdr_count++;
          if (want.masked) masked_hdrs++;
          if (want.opcode_unknown) unknown_hdrs++;
          if (want.length_overflow) sat_hdrs++;
        end else begin
          data_count++;
        end
        if (want.frame_end) frames_closed++;
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither side moves an item for too long.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (frames_if.valid && frames_if.ready) ||
        (results_if.valid && results_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
